/* hdl/mpc_horizon_cost_bicycle_defines.svh */
// assertion macros shared by the rtl files
// no dependencies; expects clk and rst_n in the scope of each use
`ifndef MPC_HORIZON_COST_BICYCLE_DEFINES_SVH
`define MPC_HORIZON_COST_BICYCLE_DEFINES_SVH

// same-cycle implication
`define MHC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mhc assertion failed");

// next-cycle implication
`define MHC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mhc assertion failed");

`endif

/* hdl/mhc_pkg.sv */
// shared types, constants and fixed point helpers of the bicycle horizon cost block
// no dependencies
package mhc_pkg;

    localparam int POLY_TERMS   = 4;
    localparam int MOD_STEPS    = 14;
    localparam int CORDIC_STEPS = 16;

    localparam logic signed [31:0] ONE_Q16      = 32'sd65536;
    localparam logic signed [31:0] PI_Q16       = 32'sd205887;
    localparam logic signed [31:0] HALF_PI_Q16  = 32'sd102944;
    localparam logic signed [32:0] TWO_PI_Q16   = 33'sd411775;
    localparam logic signed [31:0] CORDIC_GAIN  = 32'sd39797;
    localparam logic [47:0]        COST_MAX     = 48'hFFFF_FFFF_FFFF;

    localparam logic [15:0]        RST_TIME_STEP = 16'd6554;
    localparam logic [15:0]        RST_SOW       = 16'd2454;
    localparam logic signed [31:0] RST_TARGET    = 32'sd2621440;

    typedef enum logic [2:0] {
        REG_TIME_STEP = 3'd0,
        REG_SOW       = 3'd1,
        REG_TARGET    = 3'd2,
        REG_COEF_0    = 3'd3,
        REG_COEF_1    = 3'd4,
        REG_COEF_2    = 3'd5,
        REG_COEF_3    = 3'd6
    } cfg_idx_t;

    typedef enum logic [4:0] {
        S_IDLE, S_DS_CHK, S_SQ_DS, S_SQ_V, S_WB_B,
        S_PP0, S_PP1, S_PP2, S_PP3, S_PP_END, S_TERM,
        S_MOD_INIT, S_MOD, S_MOD_FIX, S_FOLD, S_CORDIC, S_SINCOS,
        S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7,
        S_POLY_A, S_POLY_B, S_POLY_END,
        S_SQ_E, S_SQ_VE, S_COST2, S_DONE
    } state_t;

    typedef enum logic [3:0] {
        ACT_NONE, ACT_LOAD, ACT_DS, ACT_TERM, ACT_MOD_INIT, ACT_MOD_STEP,
        ACT_MOD_FIX, ACT_FOLD, ACT_CORDIC, ACT_SINCOS, ACT_VERR, ACT_OUT
    } act_t;

    typedef enum logic [4:0] {
        OP_ZERO, OP_V, OP_CS, OP_SN, OP_DT, OP_SOW, OP_STEER, OP_THR,
        OP_PROD, OP_PW, OP_X, OP_COEF, OP_E, OP_VERR, OP_DS,
        OP_SQA_LO, OP_SQA_HI, OP_SQB_LO, OP_SQB_HI
    } opnd_t;

    typedef enum logic [3:0] {
        WB_NONE, WB_SQA, WB_SQB, WB_PP_LO, WB_PP_MID, WB_PP_HI,
        WB_X, WB_Y, WB_H, WB_V, WB_PW, WB_E, WB_COST
    } wb_t;

    typedef struct packed {
        act_t       act;
        opnd_t      op_a;
        opnd_t      op_b;
        wb_t        wb;
        logic [3:0] idx;
    } mhc_cmd_t;

    typedef struct packed {
        logic ds_en;
        logic out_full;
    } mhc_status_t;

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        if (v[32] != v[31])
            return v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return sat32({a[31], a} + {b[31], b});
    endfunction

    function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return sat32({a[31], a} - {b[31], b});
    endfunction

    // product >> 16 with floor, then clamp to 32 bits
    function automatic logic signed [31:0] qmul_sat(input logic signed [65:0] p);
        logic [18:0] top;
        top = p[65:47];
        if (top == '0 || top == '1)
            return p[47:16];
        return p[65] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    endfunction

    function automatic logic [47:0] cost_add(input logic [47:0] c, input logic [47:0] t);
        logic [48:0] s;
        s = {1'b0, c} + {1'b0, t};
        return s[48] ? COST_MAX : s[47:0];
    endfunction

    function automatic logic signed [31:0] atan_q16(input logic [3:0] i);
        logic signed [31:0] r;
        case (i)
            4'd0:    r = 32'sd51472;
            4'd1:    r = 32'sd30386;
            4'd2:    r = 32'sd16055;
            4'd3:    r = 32'sd8150;
            4'd4:    r = 32'sd4091;
            4'd5:    r = 32'sd2047;
            4'd6:    r = 32'sd1024;
            4'd7:    r = 32'sd512;
            4'd8:    r = 32'sd256;
            4'd9:    r = 32'sd128;
            4'd10:   r = 32'sd64;
            4'd11:   r = 32'sd32;
            4'd12:   r = 32'sd16;
            4'd13:   r = 32'sd8;
            4'd14:   r = 32'sd4;
            default: r = 32'sd2;
        endcase
        return r;
    endfunction

endpackage

/* hdl/mhc_ctrl.sv */
// sequencer of the bicycle horizon cost block: one command word per cycle
// depends on mhc_pkg and mpc_horizon_cost_bicycle_defines.svh
`include "mpc_horizon_cost_bicycle_defines.svh"

module mhc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  mhc_pkg::mhc_status_t status,
    output mhc_pkg::mhc_cmd_t    cmd
);

    mhc_pkg::state_t state_reg, state_next;
    logic [3:0]      cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mhc_pkg::S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign item_stall = (state_reg != mhc_pkg::S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd.act    = mhc_pkg::ACT_NONE;
        cmd.op_a   = mhc_pkg::OP_ZERO;
        cmd.op_b   = mhc_pkg::OP_ZERO;
        cmd.wb     = mhc_pkg::WB_NONE;
        cmd.idx    = cnt_reg;
        unique case (state_reg)
            mhc_pkg::S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.act    = mhc_pkg::ACT_LOAD;
                    state_next = mhc_pkg::S_DS_CHK;
                end
            end
            mhc_pkg::S_DS_CHK:
            begin
                cmd.act    = mhc_pkg::ACT_DS;
                state_next = status.ds_en ? mhc_pkg::S_SQ_DS : mhc_pkg::S_MOD_INIT;
            end
            mhc_pkg::S_SQ_DS:
            begin
                cmd.op_a   = mhc_pkg::OP_DS;
                cmd.op_b   = mhc_pkg::OP_DS;
                state_next = mhc_pkg::S_SQ_V;
            end
            mhc_pkg::S_SQ_V:
            begin
                cmd.op_a   = mhc_pkg::OP_V;
                cmd.op_b   = mhc_pkg::OP_V;
                cmd.wb     = mhc_pkg::WB_SQA;
                state_next = mhc_pkg::S_WB_B;
            end
            mhc_pkg::S_WB_B:
            begin
                cmd.wb     = mhc_pkg::WB_SQB;
                state_next = mhc_pkg::S_PP0;
            end
            mhc_pkg::S_PP0:
            begin
                cmd.op_a   = mhc_pkg::OP_SQA_LO;
                cmd.op_b   = mhc_pkg::OP_SQB_LO;
                state_next = mhc_pkg::S_PP1;
            end
            mhc_pkg::S_PP1:
            begin
                cmd.op_a   = mhc_pkg::OP_SQA_LO;
                cmd.op_b   = mhc_pkg::OP_SQB_HI;
                cmd.wb     = mhc_pkg::WB_PP_LO;
                state_next = mhc_pkg::S_PP2;
            end
            mhc_pkg::S_PP2:
            begin
                cmd.op_a   = mhc_pkg::OP_SQA_HI;
                cmd.op_b   = mhc_pkg::OP_SQB_LO;
                cmd.wb     = mhc_pkg::WB_PP_MID;
                state_next = mhc_pkg::S_PP3;
            end
            mhc_pkg::S_PP3:
            begin
                cmd.op_a   = mhc_pkg::OP_SQA_HI;
                cmd.op_b   = mhc_pkg::OP_SQB_HI;
                cmd.wb     = mhc_pkg::WB_PP_MID;
                state_next = mhc_pkg::S_PP_END;
            end
            mhc_pkg::S_PP_END:
            begin
                cmd.wb     = mhc_pkg::WB_PP_HI;
                state_next = mhc_pkg::S_TERM;
            end
            mhc_pkg::S_TERM:
            begin
                cmd.act    = mhc_pkg::ACT_TERM;
                state_next = mhc_pkg::S_MOD_INIT;
            end
            mhc_pkg::S_MOD_INIT:
            begin
                cmd.act    = mhc_pkg::ACT_MOD_INIT;
                cnt_next   = 4'(mhc_pkg::MOD_STEPS - 1);
                state_next = mhc_pkg::S_MOD;
            end
            mhc_pkg::S_MOD:
            begin
                cmd.act = mhc_pkg::ACT_MOD_STEP;
                if (cnt_reg == '0)
                    state_next = mhc_pkg::S_MOD_FIX;
                else
                    cnt_next = cnt_reg - 4'd1;
            end
            mhc_pkg::S_MOD_FIX:
            begin
                cmd.act    = mhc_pkg::ACT_MOD_FIX;
                state_next = mhc_pkg::S_FOLD;
            end
            mhc_pkg::S_FOLD:
            begin
                cmd.act    = mhc_pkg::ACT_FOLD;
                cnt_next   = '0;
                state_next = mhc_pkg::S_CORDIC;
            end
            mhc_pkg::S_CORDIC:
            begin
                cmd.act = mhc_pkg::ACT_CORDIC;
                if (cnt_reg == 4'(mhc_pkg::CORDIC_STEPS - 1))
                    state_next = mhc_pkg::S_SINCOS;
                else
                    cnt_next = cnt_reg + 4'd1;
            end
            mhc_pkg::S_SINCOS:
            begin
                cmd.act    = mhc_pkg::ACT_SINCOS;
                state_next = mhc_pkg::S_M0;
            end
            mhc_pkg::S_M0:
            begin
                cmd.op_a   = mhc_pkg::OP_V;
                cmd.op_b   = mhc_pkg::OP_CS;
                state_next = mhc_pkg::S_M1;
            end
            mhc_pkg::S_M1:
            begin
                cmd.op_a   = mhc_pkg::OP_PROD;
                cmd.op_b   = mhc_pkg::OP_DT;
                state_next = mhc_pkg::S_M2;
            end
            mhc_pkg::S_M2:
            begin
                cmd.op_a   = mhc_pkg::OP_V;
                cmd.op_b   = mhc_pkg::OP_SN;
                cmd.wb     = mhc_pkg::WB_X;
                state_next = mhc_pkg::S_M3;
            end
            mhc_pkg::S_M3:
            begin
                cmd.op_a   = mhc_pkg::OP_PROD;
                cmd.op_b   = mhc_pkg::OP_DT;
                state_next = mhc_pkg::S_M4;
            end
            mhc_pkg::S_M4:
            begin
                cmd.op_a   = mhc_pkg::OP_V;
                cmd.op_b   = mhc_pkg::OP_STEER;
                cmd.wb     = mhc_pkg::WB_Y;
                state_next = mhc_pkg::S_M5;
            end
            mhc_pkg::S_M5:
            begin
                cmd.op_a   = mhc_pkg::OP_PROD;
                cmd.op_b   = mhc_pkg::OP_SOW;
                state_next = mhc_pkg::S_M6;
            end
            mhc_pkg::S_M6:
            begin
                cmd.op_a   = mhc_pkg::OP_THR;
                cmd.op_b   = mhc_pkg::OP_DT;
                cmd.wb     = mhc_pkg::WB_H;
                state_next = mhc_pkg::S_M7;
            end
            mhc_pkg::S_M7:
            begin
                cmd.wb     = mhc_pkg::WB_V;
                cnt_next   = '0;
                state_next = mhc_pkg::S_POLY_A;
            end
            mhc_pkg::S_POLY_A:
            begin
                cmd.op_a   = mhc_pkg::OP_PW;
                cmd.op_b   = mhc_pkg::OP_X;
                cmd.wb     = (cnt_reg != '0) ? mhc_pkg::WB_E : mhc_pkg::WB_NONE;
                state_next = mhc_pkg::S_POLY_B;
            end
            mhc_pkg::S_POLY_B:
            begin
                cmd.op_a = mhc_pkg::OP_COEF;
                cmd.op_b = mhc_pkg::OP_PW;
                cmd.wb   = mhc_pkg::WB_PW;
                if (cnt_reg == 4'(mhc_pkg::POLY_TERMS - 1))
                    state_next = mhc_pkg::S_POLY_END;
                else
                begin
                    cnt_next   = cnt_reg + 4'd1;
                    state_next = mhc_pkg::S_POLY_A;
                end
            end
            mhc_pkg::S_POLY_END:
            begin
                cmd.wb     = mhc_pkg::WB_E;
                cmd.act    = mhc_pkg::ACT_VERR;
                state_next = mhc_pkg::S_SQ_E;
            end
            mhc_pkg::S_SQ_E:
            begin
                cmd.op_a   = mhc_pkg::OP_E;
                cmd.op_b   = mhc_pkg::OP_E;
                state_next = mhc_pkg::S_SQ_VE;
            end
            mhc_pkg::S_SQ_VE:
            begin
                cmd.op_a   = mhc_pkg::OP_VERR;
                cmd.op_b   = mhc_pkg::OP_VERR;
                cmd.wb     = mhc_pkg::WB_COST;
                state_next = mhc_pkg::S_COST2;
            end
            mhc_pkg::S_COST2:
            begin
                cmd.wb     = mhc_pkg::WB_COST;
                state_next = mhc_pkg::S_DONE;
            end
            mhc_pkg::S_DONE:
            begin
                if (!status.out_full)
                begin
                    cmd.act    = mhc_pkg::ACT_OUT;
                    state_next = mhc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mhc_pkg::S_IDLE;
            end
        endcase
    end

    `MHC_ASSERT_NXT(a_accept_starts, state_reg == mhc_pkg::S_IDLE && item_valid,
                    state_reg == mhc_pkg::S_DS_CHK)
    `MHC_ASSERT_NXT(a_mod_stays, state_reg == mhc_pkg::S_MOD,
                    state_reg == mhc_pkg::S_MOD || state_reg == mhc_pkg::S_MOD_FIX)
    `MHC_ASSERT_IMP(a_pp_needs_ds, state_reg == mhc_pkg::S_PP0, status.ds_en)

endmodule

/* hdl/mhc_dp.sv */
// datapath: state, config registers, shared multiplier, cordic and cost accumulation
// depends on mhc_pkg
module mhc_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mhc_pkg::mhc_cmd_t    cmd,
    output mhc_pkg::mhc_status_t status,
    input  logic                 cfg_wr,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 first_step,
    input  logic signed [31:0]   init_pos_x,
    input  logic signed [31:0]   init_pos_y,
    input  logic signed [31:0]   init_heading,
    input  logic signed [31:0]   init_speed,
    input  logic signed [31:0]   steer_cmd,
    input  logic signed [31:0]   throttle_cmd,
    input  logic                 last_step,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic signed [31:0]   pos_x,
    output logic signed [31:0]   pos_y,
    output logic signed [31:0]   heading,
    output logic signed [31:0]   speed,
    output logic [47:0]          cost_so_far,
    output logic                 cost_final
);

    logic [15:0]        dt_reg, sow_reg;
    logic signed [31:0] tgt_reg;
    logic signed [31:0] coef_reg [4];

    logic signed [31:0] steer_reg, thr_reg;
    logic               last_reg;
    logic signed [31:0] x_reg, y_reg, h_reg, v_reg, prev_reg;
    logic [47:0]        cost_reg;
    logic               open_reg, ds_en_reg;

    logic signed [31:0] ds_reg, e_reg, pw_reg, verr_reg;
    logic [46:0]        sqa_reg, sqb_reg;
    logic [93:0]        acc_reg;

    logic [32:0]        r_reg;
    logic               rneg_reg, flip_reg;
    logic signed [31:0] cx_reg, cy_reg, z_reg, sn_reg, cs_reg;

    logic signed [65:0] p_reg;
    logic signed [32:0] op_a, op_b;
    logic signed [31:0] prod_q;

    logic               out_valid_reg;
    logic signed [31:0] ox_reg, oy_reg, oh_reg, ov_reg;
    logic [47:0]        ocost_reg;
    logic               ofinal_reg;

    logic signed [32:0] mod_c, rs, rw;
    logic signed [31:0] dx, dy, at;
    logic [47:0]        term;

    function automatic logic signed [32:0] pick(input mhc_pkg::opnd_t s);
        logic signed [32:0] r;
        case (s)
            mhc_pkg::OP_V:      r = {v_reg[31], v_reg};
            mhc_pkg::OP_CS:     r = {cs_reg[31], cs_reg};
            mhc_pkg::OP_SN:     r = {sn_reg[31], sn_reg};
            mhc_pkg::OP_DT:     r = {17'd0, dt_reg};
            mhc_pkg::OP_SOW:    r = {17'd0, sow_reg};
            mhc_pkg::OP_STEER:  r = {steer_reg[31], steer_reg};
            mhc_pkg::OP_THR:    r = {thr_reg[31], thr_reg};
            mhc_pkg::OP_PROD:   r = {prod_q[31], prod_q};
            mhc_pkg::OP_PW:     r = {pw_reg[31], pw_reg};
            mhc_pkg::OP_X:      r = {x_reg[31], x_reg};
            mhc_pkg::OP_COEF:   r = {coef_reg[cmd.idx[1:0]][31], coef_reg[cmd.idx[1:0]]};
            mhc_pkg::OP_E:      r = {e_reg[31], e_reg};
            mhc_pkg::OP_VERR:   r = {verr_reg[31], verr_reg};
            mhc_pkg::OP_DS:     r = {ds_reg[31], ds_reg};
            mhc_pkg::OP_SQA_LO: r = {10'd0, sqa_reg[22:0]};
            mhc_pkg::OP_SQA_HI: r = {9'd0, sqa_reg[46:23]};
            mhc_pkg::OP_SQB_LO: r = {10'd0, sqb_reg[22:0]};
            mhc_pkg::OP_SQB_HI: r = {9'd0, sqb_reg[46:23]};
            default:            r = '0;
        endcase
        return r;
    endfunction

    // operand select follows every register the selector reads
    always_comb
    begin
        op_a = pick(cmd.op_a);
        op_b = pick(cmd.op_b);
    end

    assign prod_q = mhc_pkg::qmul_sat(p_reg);

    // shared multiplier, result registered
    always_ff @(posedge clk)
    begin
        p_reg <= op_a * op_b;
    end

    // heading reduction and cordic helpers
    always_comb
    begin
        mod_c = mhc_pkg::TWO_PI_Q16 <<< cmd.idx;
        rs    = rneg_reg ? -$signed(r_reg) : $signed(r_reg);
        rw    = rs;
        if (rw < 0)
            rw = rw + mhc_pkg::TWO_PI_Q16;
        if (rw > {mhc_pkg::PI_Q16[31], mhc_pkg::PI_Q16})
            rw = rw - mhc_pkg::TWO_PI_Q16;
        dx   = cy_reg >>> cmd.idx;
        dy   = cx_reg >>> cmd.idx;
        at   = mhc_pkg::atan_q16(cmd.idx);
        term = (acc_reg[93:64] != '0) ? mhc_pkg::COST_MAX : acc_reg[63:16];
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_reg      <= mhc_pkg::RST_TIME_STEP;
            sow_reg     <= mhc_pkg::RST_SOW;
            tgt_reg     <= mhc_pkg::RST_TARGET;
            coef_reg[0] <= '0;
            coef_reg[1] <= '0;
            coef_reg[2] <= '0;
            coef_reg[3] <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (mhc_pkg::cfg_idx_t'(cfg_index))
                mhc_pkg::REG_TIME_STEP: dt_reg      <= cfg_data[15:0];
                mhc_pkg::REG_SOW:       sow_reg     <= cfg_data[15:0];
                mhc_pkg::REG_TARGET:    tgt_reg     <= cfg_data;
                mhc_pkg::REG_COEF_0:    coef_reg[0] <= cfg_data;
                mhc_pkg::REG_COEF_1:    coef_reg[1] <= cfg_data;
                mhc_pkg::REG_COEF_2:    coef_reg[2] <= cfg_data;
                mhc_pkg::REG_COEF_3:    coef_reg[3] <= cfg_data;
                default:                ;
            endcase
        end
    end

    // vehicle state and cost (architectural, reset to zero)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg     <= '0;
            y_reg     <= '0;
            h_reg     <= '0;
            v_reg     <= '0;
            prev_reg  <= '0;
            cost_reg  <= '0;
            open_reg  <= 1'b0;
            ds_en_reg <= 1'b0;
        end
        else
        begin
            case (cmd.act)
                mhc_pkg::ACT_LOAD:
                begin
                    ds_en_reg <= !first_step && open_reg;
                    if (first_step)
                    begin
                        x_reg    <= init_pos_x;
                        y_reg    <= init_pos_y;
                        h_reg    <= init_heading;
                        v_reg    <= init_speed;
                        cost_reg <= '0;
                    end
                end
                mhc_pkg::ACT_TERM: cost_reg <= mhc_pkg::cost_add(cost_reg, term);
                mhc_pkg::ACT_OUT:
                begin
                    prev_reg <= steer_reg;
                    open_reg <= !last_reg;
                end
                default: ;
            endcase
            case (cmd.wb)
                mhc_pkg::WB_X:    x_reg <= mhc_pkg::qadd(x_reg, prod_q);
                mhc_pkg::WB_Y:    y_reg <= mhc_pkg::qadd(y_reg, prod_q);
                mhc_pkg::WB_H:    h_reg <= mhc_pkg::qadd(h_reg, prod_q);
                mhc_pkg::WB_V:    v_reg <= mhc_pkg::qadd(v_reg, prod_q);
                mhc_pkg::WB_COST: cost_reg <= mhc_pkg::cost_add(cost_reg, {1'b0, p_reg[62:16]});
                default: ;
            endcase
        end
    end

    // working registers of one step
    always_ff @(posedge clk)
    begin
        case (cmd.act)
            mhc_pkg::ACT_LOAD:
            begin
                steer_reg <= steer_cmd;
                thr_reg   <= throttle_cmd;
                last_reg  <= last_step;
            end
            mhc_pkg::ACT_DS:       ds_reg <= mhc_pkg::qsub(steer_reg, prev_reg);
            mhc_pkg::ACT_MOD_INIT:
            begin
                r_reg    <= h_reg[31] ? -{h_reg[31], h_reg} : {1'b0, h_reg};
                rneg_reg <= h_reg[31];
            end
            mhc_pkg::ACT_MOD_STEP:
            begin
                if (r_reg >= mod_c)
                    r_reg <= r_reg - mod_c;
            end
            mhc_pkg::ACT_MOD_FIX:  z_reg <= rw[31:0];
            mhc_pkg::ACT_FOLD:
            begin
                cx_reg <= mhc_pkg::CORDIC_GAIN;
                cy_reg <= '0;
                if (z_reg > mhc_pkg::HALF_PI_Q16)
                begin
                    z_reg    <= z_reg - mhc_pkg::PI_Q16;
                    flip_reg <= 1'b1;
                end
                else if (z_reg < -mhc_pkg::HALF_PI_Q16)
                begin
                    z_reg    <= z_reg + mhc_pkg::PI_Q16;
                    flip_reg <= 1'b1;
                end
                else
                    flip_reg <= 1'b0;
            end
            mhc_pkg::ACT_CORDIC:
            begin
                if (!z_reg[31])
                begin
                    cx_reg <= cx_reg - dx;
                    cy_reg <= cy_reg + dy;
                    z_reg  <= z_reg - at;
                end
                else
                begin
                    cx_reg <= cx_reg + dx;
                    cy_reg <= cy_reg - dy;
                    z_reg  <= z_reg + at;
                end
            end
            mhc_pkg::ACT_SINCOS:
            begin
                sn_reg <= flip_reg ? -cy_reg : cy_reg;
                cs_reg <= flip_reg ? -cx_reg : cx_reg;
            end
            mhc_pkg::ACT_VERR:     verr_reg <= mhc_pkg::qsub(v_reg, tgt_reg);
            default: ;
        endcase
        case (cmd.wb)
            mhc_pkg::WB_SQA:    sqa_reg <= p_reg[62:16];
            mhc_pkg::WB_SQB:    sqb_reg <= p_reg[62:16];
            mhc_pkg::WB_PP_LO:  acc_reg <= 94'(p_reg[47:0]);
            mhc_pkg::WB_PP_MID: acc_reg <= acc_reg + (94'(p_reg[47:0]) << 23);
            mhc_pkg::WB_PP_HI:  acc_reg <= acc_reg + (94'(p_reg[47:0]) << 46);
            mhc_pkg::WB_V:
            begin
                e_reg  <= mhc_pkg::qsub('0, y_reg);
                pw_reg <= mhc_pkg::ONE_Q16;
            end
            mhc_pkg::WB_PW:     pw_reg <= prod_q;
            mhc_pkg::WB_E:      e_reg  <= mhc_pkg::qadd(e_reg, prod_q);
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.act == mhc_pkg::ACT_OUT)
            out_valid_reg <= 1'b1;
        else if (!result_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.act == mhc_pkg::ACT_OUT)
        begin
            ox_reg     <= x_reg;
            oy_reg     <= y_reg;
            oh_reg     <= h_reg;
            ov_reg     <= v_reg;
            ocost_reg  <= cost_reg;
            ofinal_reg <= last_reg;
        end
    end

    assign status.ds_en    = ds_en_reg;
    assign status.out_full = out_valid_reg && result_stall;

    assign result_valid = out_valid_reg;
    assign pos_x        = ox_reg;
    assign pos_y        = oy_reg;
    assign heading      = oh_reg;
    assign speed        = ov_reg;
    assign cost_so_far  = ocost_reg;
    assign cost_final   = ofinal_reg;

endmodule

/* hdl/mpc_horizon_cost_bicycle.sv */
// the block takes no new item until the result of the last one is loaded into its output register
// the pace of items is set by the 14-step heading modulo, the 16-step
// cordic and the single shared 33x33 multiplier that carries all products in turn
// reset: asynchronous active low; clears state, cost and horizon flag, loads config defaults
// a finished result waits in its output register while the next item is taken
// depends on mhc_pkg, mhc_ctrl, mhc_dp and mpc_horizon_cost_bicycle_defines.svh
`include "mpc_horizon_cost_bicycle_defines.svh"

module mpc_horizon_cost_bicycle (
    input  logic               clk,
    input  logic               rst_n,
    // config write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    // item channel
    input  logic               item_valid,
    output logic               item_stall,
    input  logic               first_step,
    input  logic signed [31:0] init_pos_x,
    input  logic signed [31:0] init_pos_y,
    input  logic signed [31:0] init_heading,
    input  logic signed [31:0] init_speed,
    input  logic signed [31:0] steer_cmd,
    input  logic signed [31:0] throttle_cmd,
    input  logic               last_step,
    // result channel
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] heading,
    output logic signed [31:0] speed,
    output logic [47:0]        cost_so_far,
    output logic               cost_final
);

    mhc_pkg::mhc_cmd_t    cmd;
    mhc_pkg::mhc_status_t status;

    // config writes are taken at any time; the user writes only while idle
    assign cfg_ready = 1'b1;

    // sequencer: walks steering term, heading reduction, cordic, model update and cost
    mhc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    // datapath: item fields are sampled on the transfer cycle by the load command
    mhc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_wr       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .first_step   (first_step),
        .init_pos_x   (init_pos_x),
        .init_pos_y   (init_pos_y),
        .init_heading (init_heading),
        .init_speed   (init_speed),
        .steer_cmd    (steer_cmd),
        .throttle_cmd (throttle_cmd),
        .last_step    (last_step),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .heading      (heading),
        .speed        (speed),
        .cost_so_far  (cost_so_far),
        .cost_final   (cost_final)
    );

    // an accepted item keeps the block busy on the next cycle
    `MHC_ASSERT_NXT(a_busy_after_transfer, item_valid && !item_stall, item_stall)
    // loading a result always shows it on the port next cycle
    `MHC_ASSERT_NXT(a_result_shown, cmd.act == mhc_pkg::ACT_OUT, result_valid)
    // a stalled result stays on the port unchanged
    `MHC_ASSERT_NXT(a_result_held, result_valid && result_stall, result_valid && $stable(cost_so_far))

endmodule
